// ===== design/sleep_aware_alarm_volume_ramp_assert.svh =====
// Assertion macros shared by the alarm volume ramp modules
`ifndef SLEEP_AWARE_ALARM_VOLUME_RAMP_ASSERT_SVH
`define SLEEP_AWARE_ALARM_VOLUME_RAMP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SAVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SAVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sava_pkg.sv =====
// Types, codes and reset constants of the alarm volume ramp
`default_nettype none
package sava_pkg;

  localparam int unsigned VOL_W  = 6;
  localparam int unsigned MS_W   = 20;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [1:0] CMD_TRIGGER = 2'd0;
  localparam logic [1:0] CMD_POLL    = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;

  localparam logic [1:0] STAGE_UNKNOWN = 2'd0;
  localparam logic [1:0] STAGE_WAKE    = 2'd1;
  localparam logic [1:0] STAGE_REM     = 2'd2;
  localparam logic [1:0] STAGE_NREM    = 2'd3;

  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_WAKE = 2'd1;
  localparam logic [1:0] CAUSE_KEY  = 2'd2;
  localparam logic [1:0] CAUSE_CMD  = 2'd3;

  localparam logic [IDX_W-1:0] REG_START_VOLUME  = 3'd0;
  localparam logic [IDX_W-1:0] REG_REM_LEVEL     = 3'd1;
  localparam logic [IDX_W-1:0] REG_VOL_CEILING   = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLUME_STEP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_INC_PERIOD_MS = 3'd4;
  localparam logic [IDX_W-1:0] REG_WAKE_STOP_MS  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SUPPRESS_MS   = 3'd6;
  localparam logic [IDX_W-1:0] REG_IDLE_VOLUME   = 3'd7;

  localparam logic [VOL_W-1:0] RST_START_VOLUME  = 6'd6;
  localparam logic [VOL_W-1:0] RST_REM_LEVEL     = 6'd18;
  localparam logic [VOL_W-1:0] RST_VOL_CEILING   = 6'd33;
  localparam logic [VOL_W-1:0] RST_VOLUME_STEP   = 6'd2;
  localparam logic [MS_W-1:0]  RST_INC_PERIOD_MS = 20'd20000;
  localparam logic [MS_W-1:0]  RST_WAKE_STOP_MS  = 20'd30000;
  localparam logic [MS_W-1:0]  RST_SUPPRESS_MS   = 20'd70000;
  localparam logic [VOL_W-1:0] RST_IDLE_VOLUME   = 6'd20;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] now_ms;
    logic [1:0]        sleep_stage;
    logic              key_pressed;
  } sava_in_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic             volume_written;
    logic             ringing;
    logic [1:0]       stop_cause;
  } sava_out_t;

  typedef struct packed {
    logic [VOL_W-1:0] start_volume;
    logic [VOL_W-1:0] rem_level;
    logic [VOL_W-1:0] vol_ceiling;
    logic [VOL_W-1:0] volume_step;
    logic [MS_W-1:0]  increase_period_ms;
    logic [MS_W-1:0]  wake_stop_ms;
    logic [MS_W-1:0]  suppress_ms;
    logic [VOL_W-1:0] idle_volume;
  } sava_cfg_t;

  typedef struct packed {
    logic              ringing;
    logic [VOL_W-1:0]  volume;
    logic [1:0]        prev_stage;
    logic [TIME_W-1:0] last_inc_time;
    logic [TIME_W-1:0] wake_seen_time;
    logic [TIME_W-1:0] suppress_until;
  } sava_state_t;

endpackage
`default_nettype wire

// ===== design/sleep_aware_alarm_volume_ramp.sv =====
// Sleep-aware alarm volume ramp: top level with request and result registers
//
// Each request (trigger, poll tick or stop) is captured in an input register,
// evaluated against the alarm state in one pass, and its single result lands in
// a result register. One request is accepted every
// cycle; the rate is set by the state update in the core, and a held
// result stalls input only once both registers are full. Configuration writes
// take effect on the next cycle and belong to idle periods.
`default_nettype none
`include "sleep_aware_alarm_volume_ramp_assert.svh"
module sleep_aware_alarm_volume_ramp
  import sava_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sava_in_t         in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sava_out_t             out_rsp,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [MS_W-1:0]  cfg_wdata
);

  sava_cfg_t cfg;
  sava_in_t  in_req_r;
  sava_out_t out_rsp_r;
  sava_out_t step_rsp;
  logic      in_vld_r;
  logic      in_vld_nxt;
  logic      out_vld_r;
  logic      out_vld_nxt;
  logic      advance;
  logic      step_en;

  sava_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sava_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (step_en),
    .req     (in_req_r),
    .rsp     (step_rsp)
  );

  assign advance  = !out_vld_r || out_ready;
  assign step_en  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step_en) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (step_en) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= in_req;
    end
    if (step_en) begin
      out_rsp_r <= step_rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  `SAVA_ASSERT_NOW(a_stall_only_when_full, !in_ready,
                   in_vld_r && out_vld_r && !out_ready, "request stalled with room free")
  `SAVA_ASSERT_NOW(a_stop_not_ringing, out_vld_r && out_rsp_r.stop_cause != CAUSE_NONE,
                   !out_rsp_r.ringing && out_rsp_r.volume_written, "stop result still ringing")
  `SAVA_ASSERT_NEXT(a_result_from_request, step_en,
                    out_vld_r && out_rsp_r == $past(step_rsp), "result not captured")

endmodule
`default_nettype wire

// ===== design/sava_cfg_regs.sv =====
// Configuration register file of the alarm volume ramp
`default_nettype none
module sava_cfg_regs
  import sava_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_idx,
  input  wire logic [MS_W-1:0]  cfg_wdata,
  output sava_cfg_t             cfg
);

  sava_cfg_t cfg_r;
  sava_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_START_VOLUME:  cfg_nxt.start_volume       = cfg_wdata[VOL_W-1:0];
        REG_REM_LEVEL:     cfg_nxt.rem_level          = cfg_wdata[VOL_W-1:0];
        REG_VOL_CEILING:   cfg_nxt.vol_ceiling        = cfg_wdata[VOL_W-1:0];
        REG_VOLUME_STEP:   cfg_nxt.volume_step        = cfg_wdata[VOL_W-1:0];
        REG_INC_PERIOD_MS: cfg_nxt.increase_period_ms = cfg_wdata;
        REG_WAKE_STOP_MS:  cfg_nxt.wake_stop_ms       = cfg_wdata;
        REG_SUPPRESS_MS:   cfg_nxt.suppress_ms        = cfg_wdata;
        REG_IDLE_VOLUME:   cfg_nxt.idle_volume        = cfg_wdata[VOL_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_volume       <= RST_START_VOLUME;
      cfg_r.rem_level          <= RST_REM_LEVEL;
      cfg_r.vol_ceiling        <= RST_VOL_CEILING;
      cfg_r.volume_step        <= RST_VOLUME_STEP;
      cfg_r.increase_period_ms <= RST_INC_PERIOD_MS;
      cfg_r.wake_stop_ms       <= RST_WAKE_STOP_MS;
      cfg_r.suppress_ms        <= RST_SUPPRESS_MS;
      cfg_r.idle_volume        <= RST_IDLE_VOLUME;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== design/sava_core.sv =====
// Alarm state registers and single-pass request evaluation
`default_nettype none
`include "sleep_aware_alarm_volume_ramp_assert.svh"
module sava_core
  import sava_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sava_cfg_t cfg,
  input  wire logic      step_en,
  input  wire sava_in_t  req,
  output sava_out_t      rsp
);

  sava_state_t st_r;
  sava_state_t st_nxt;

  logic [TIME_W-1:0] supp_left;
  logic              blocked;
  logic              deep;
  logic [TIME_W-1:0] wake_t;
  logic [TIME_W-1:0] last_t;
  logic [TIME_W-1:0] wake_age;
  logic [TIME_W-1:0] inc_age;
  logic [VOL_W:0]    vol_sum;
  logic [VOL_W-1:0]  vol_ramp;
  logic              written;
  logic [1:0]        cause;

  always_comb begin
    st_nxt    = st_r;
    written   = 1'b0;
    cause     = CAUSE_NONE;
    supp_left = st_r.suppress_until - req.now_ms;
    blocked   = st_r.ringing ||
                (st_r.suppress_until != '0 && supp_left != '0 &&
                 supp_left <= {{(TIME_W-MS_W){1'b0}}, cfg.suppress_ms});
    deep      = (req.sleep_stage == STAGE_NREM) || (req.sleep_stage == STAGE_UNKNOWN);
    wake_t    = st_r.wake_seen_time;
    last_t    = st_r.last_inc_time;
    if (req.sleep_stage != st_r.prev_stage) begin
      if (req.sleep_stage == STAGE_WAKE) begin
        wake_t = req.now_ms;
      end
      if (deep) begin
        last_t = req.now_ms;
      end
    end
    wake_age = req.now_ms - wake_t;
    inc_age  = req.now_ms - last_t;
    vol_sum  = {1'b0, st_r.volume} + {1'b0, cfg.volume_step};
    vol_ramp = (vol_sum > {1'b0, cfg.vol_ceiling}) ? cfg.vol_ceiling : vol_sum[VOL_W-1:0];

    unique case (req.command)
      CMD_TRIGGER: begin
        if (!blocked) begin
          st_nxt.ringing        = 1'b1;
          st_nxt.volume         = cfg.start_volume;
          st_nxt.last_inc_time  = req.now_ms;
          st_nxt.wake_seen_time = '0;
          st_nxt.prev_stage     = STAGE_UNKNOWN;
          written               = 1'b1;
        end
      end
      CMD_STOP: begin
        if (st_r.ringing) begin
          st_nxt.ringing = 1'b0;
          st_nxt.volume  = cfg.idle_volume;
          written        = 1'b1;
          cause          = CAUSE_CMD;
        end
      end
      CMD_POLL: begin
        if (st_r.ringing) begin
          st_nxt.prev_stage    = req.sleep_stage;
          st_nxt.last_inc_time = last_t;
          if (req.sleep_stage == STAGE_WAKE) begin
            if (wake_t == '0) begin
              st_nxt.wake_seen_time = req.now_ms;
            end else begin
              st_nxt.wake_seen_time = wake_t;
              if (wake_age >= {{(TIME_W-MS_W){1'b0}}, cfg.wake_stop_ms}) begin
                cause = CAUSE_WAKE;
              end
            end
          end else begin
            st_nxt.wake_seen_time = '0;
          end
          if (cause == CAUSE_NONE) begin
            if (req.sleep_stage == STAGE_REM) begin
              if (st_r.volume != cfg.rem_level) begin
                st_nxt.volume = cfg.rem_level;
                written       = 1'b1;
              end
            end else if (deep && st_r.volume < cfg.vol_ceiling) begin
              if (inc_age >= {{(TIME_W-MS_W){1'b0}}, cfg.increase_period_ms}) begin
                if (vol_ramp != st_r.volume) begin
                  st_nxt.volume = vol_ramp;
                  written       = 1'b1;
                end
                st_nxt.last_inc_time = req.now_ms;
              end
            end
            if (req.key_pressed) begin
              st_nxt.suppress_until = req.now_ms +
                                      {{(TIME_W-MS_W){1'b0}}, cfg.suppress_ms};
              cause = CAUSE_KEY;
            end
          end
          if (cause != CAUSE_NONE) begin
            st_nxt.ringing = 1'b0;
            st_nxt.volume  = cfg.idle_volume;
            written        = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase

    rsp.volume         = st_nxt.volume;
    rsp.volume_written = written;
    rsp.ringing        = st_nxt.ringing;
    rsp.stop_cause     = cause;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.ringing        <= 1'b0;
      st_r.volume         <= RST_IDLE_VOLUME;
      st_r.prev_stage     <= STAGE_UNKNOWN;
      st_r.last_inc_time  <= '0;
      st_r.wake_seen_time <= '0;
      st_r.suppress_until <= '0;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

  `SAVA_ASSERT_NEXT(a_ring_state_tracks, step_en,
                    st_r.ringing == $past(rsp.ringing), "ringing state lost")
  `SAVA_ASSERT_NOW(a_stop_idle_volume, step_en && rsp.stop_cause != CAUSE_NONE,
                   rsp.volume == cfg.idle_volume && !rsp.ringing, "stop without idle volume")
  `SAVA_ASSERT_NOW(a_ramp_ceiling,
                   step_en && req.command == CMD_POLL && rsp.ringing && deep &&
                   st_r.volume <= cfg.vol_ceiling,
                   rsp.volume <= cfg.vol_ceiling, "ramp passed ceiling")

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sleep-aware alarm volume ramp
module testbench;
  import sava_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  sava_in_t         in_req;
  logic             out_valid;
  logic             out_ready;
  sava_out_t        out_rsp;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [MS_W-1:0]  cfg_wdata;

  sleep_aware_alarm_volume_ramp DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  sava_cfg_t         alarm_cfg;
  logic              alarm_on;
  logic [VOL_W-1:0]  cur_volume;
  logic [1:0]        prior_stage;
  logic [TIME_W-1:0] last_step_ms;
  logic [TIME_W-1:0] wake_since_ms;
  logic [TIME_W-1:0] quiet_until_ms;

  sava_out_t alarm_rsp_due[$];
  int        mismatches;
  int        cycle_count;
  int        live_items;
  int        rx_wait;
  bit        tx_gaps_on;
  bit        rx_stalls_on;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic sava_out_t predict_alarm_step(sava_in_t r);
    sava_out_t         o;
    logic              written;
    logic [1:0]        cause;
    logic              blocked;
    logic              deep;
    logic [TIME_W-1:0] left;
    logic [VOL_W:0]    next_vol;
    written = 1'b0;
    cause = CAUSE_NONE;
    if (r.command == CMD_TRIGGER) begin
      blocked = alarm_on;
      if (!blocked && quiet_until_ms != '0) begin
        left = quiet_until_ms - r.now_ms;
        if (left != '0 && left <= alarm_cfg.suppress_ms) blocked = 1'b1;
      end
      if (!blocked) begin
        alarm_on = 1'b1;
        cur_volume = alarm_cfg.start_volume;
        last_step_ms = r.now_ms;
        wake_since_ms = '0;
        prior_stage = STAGE_UNKNOWN;
        written = 1'b1;
      end
    end else if (r.command == CMD_STOP) begin
      if (alarm_on) begin
        alarm_on = 1'b0;
        cur_volume = alarm_cfg.idle_volume;
        written = 1'b1;
        cause = CAUSE_CMD;
      end
    end else if (r.command == CMD_POLL && alarm_on) begin
      deep = (r.sleep_stage == STAGE_NREM) || (r.sleep_stage == STAGE_UNKNOWN);
      if (r.sleep_stage != prior_stage) begin
        if (r.sleep_stage == STAGE_WAKE) wake_since_ms = r.now_ms;
        if (deep) last_step_ms = r.now_ms;
        prior_stage = r.sleep_stage;
      end
      if (r.sleep_stage == STAGE_WAKE) begin
        if (wake_since_ms == '0) begin
          wake_since_ms = r.now_ms;
        end else if (TIME_W'(r.now_ms - wake_since_ms) >= alarm_cfg.wake_stop_ms) begin
          cause = CAUSE_WAKE;
        end
      end else begin
        wake_since_ms = '0;
      end
      if (cause == CAUSE_NONE) begin
        if (r.sleep_stage == STAGE_REM) begin
          if (cur_volume != alarm_cfg.rem_level) begin
            cur_volume = alarm_cfg.rem_level;
            written = 1'b1;
          end
        end else if (deep && cur_volume < alarm_cfg.vol_ceiling) begin
          if (TIME_W'(r.now_ms - last_step_ms) >= alarm_cfg.increase_period_ms) begin
            next_vol = {1'b0, cur_volume} + {1'b0, alarm_cfg.volume_step};
            if (next_vol > {1'b0, alarm_cfg.vol_ceiling})
              next_vol = {1'b0, alarm_cfg.vol_ceiling};
            if (next_vol[VOL_W-1:0] != cur_volume) begin
              cur_volume = next_vol[VOL_W-1:0];
              written = 1'b1;
            end
            last_step_ms = r.now_ms;
          end
        end
        if (r.key_pressed) begin
          quiet_until_ms = r.now_ms + alarm_cfg.suppress_ms;
          cause = CAUSE_KEY;
        end
      end
      if (cause != CAUSE_NONE) begin
        alarm_on = 1'b0;
        cur_volume = alarm_cfg.idle_volume;
        written = 1'b1;
      end
    end
    o.volume = cur_volume;
    o.volume_written = written;
    o.ringing = alarm_on;
    o.stop_cause = cause;
    return o;
  endfunction

  task automatic send_request(logic [1:0] cmd, logic [TIME_W-1:0] now, logic [1:0] stage,
                              logic key);
    sava_in_t req;
    int       gap;
    logic     was_on;
    req.command = cmd;
    req.now_ms = now;
    req.sleep_stage = stage;
    req.key_pressed = key;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    was_on = alarm_on;
    alarm_rsp_due.push_back(predict_alarm_step(req));
    if (was_on || alarm_on) live_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [MS_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_config(sava_cfg_t c);
    in_valid <= 1'b0;
    while (alarm_rsp_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_START_VOLUME, MS_W'(c.start_volume));
    write_reg(REG_REM_LEVEL, MS_W'(c.rem_level));
    write_reg(REG_VOL_CEILING, MS_W'(c.vol_ceiling));
    write_reg(REG_VOLUME_STEP, MS_W'(c.volume_step));
    write_reg(REG_INC_PERIOD_MS, c.increase_period_ms);
    write_reg(REG_WAKE_STOP_MS, c.wake_stop_ms);
    write_reg(REG_SUPPRESS_MS, c.suppress_ms);
    write_reg(REG_IDLE_VOLUME, MS_W'(c.idle_volume));
    cfg_we <= 1'b0;
    alarm_cfg = c;
  endtask

  function automatic logic [MS_W-1:0] pick_ms();
    return ($urandom_range(0, 5) == 0) ? MS_W'($urandom) : MS_W'($urandom_range(0, 4000));
  endfunction

  always @(negedge clk) begin
    if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sava_out_t want;
    if (rst_n && out_valid && out_ready) begin
      rx_wait = rx_stalls_on ? $urandom_range(0, 6) : 0;
      if (alarm_rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: vol=%0d wr=%0b ring=%0b cause=%0d", out_rsp.volume,
                   out_rsp.volume_written, out_rsp.ringing, out_rsp.stop_cause);
      end else begin
        want = alarm_rsp_due.pop_front();
        if (out_rsp.volume !== want.volume || out_rsp.volume_written !== want.volume_written ||
            out_rsp.ringing !== want.ringing || out_rsp.stop_cause !== want.stop_cause) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: expected vol=%0d wr=%0b ring=%0b cause=%0d, ",
                   want.volume, want.volume_written, want.ringing, want.stop_cause);
            $display("got vol=%0d wr=%0b ring=%0b cause=%0d",
                     out_rsp.volume, out_rsp.volume_written, out_rsp.ringing,
                     out_rsp.stop_cause);
          end
        end
      end
    end
  end

  task automatic test_default_ramp();
    send_request(CMD_POLL, 32'd0, STAGE_NREM, 1'b1);
    send_request(CMD_STOP, 32'hFFFF_FFFF, STAGE_WAKE, 1'b0);
    send_request(2'd3, 32'd100, STAGE_REM, 1'b1);
    send_request(CMD_TRIGGER, 32'd1000, STAGE_WAKE, 1'b1);
    send_request(CMD_TRIGGER, 32'd1500, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'd2000, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'd22000, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'd23000, STAGE_REM, 1'b0);
    send_request(CMD_POLL, 32'd24000, STAGE_WAKE, 1'b0);
    send_request(CMD_POLL, 32'd54000, STAGE_WAKE, 1'b0);
    send_request(CMD_TRIGGER, 32'd60000, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'd61000, STAGE_UNKNOWN, 1'b1);
    send_request(CMD_TRIGGER, 32'd100000, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_TRIGGER, 32'd131000, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_STOP, 32'd132000, STAGE_REM, 1'b1);
  endtask

  task automatic test_wake_zero_and_wrap();
    send_request(CMD_TRIGGER, 32'hFFFF_F000, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'hFFFF_F100, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'h0000_4E00, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'd0, STAGE_WAKE, 1'b0);
    send_request(CMD_POLL, 32'd40000, STAGE_WAKE, 1'b0);
    send_request(CMD_POLL, 32'd70000, STAGE_WAKE, 1'b0);
  endtask

  task automatic test_config_extremes();
    sava_cfg_t c;
    apply_config('0);
    send_request(CMD_TRIGGER, 32'd5000, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'd5002, STAGE_WAKE, 1'b0);
    send_request(CMD_TRIGGER, 32'd5003, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'd5004, STAGE_REM, 1'b1);
    apply_config('1);
    send_request(CMD_TRIGGER, 32'd0, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'h000F_FFFF, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'h0010_0000, STAGE_WAKE, 1'b1);
    send_request(CMD_TRIGGER, 32'h0010_0001, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_TRIGGER, 32'd0, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_STOP, 32'd1, STAGE_UNKNOWN, 1'b0);
    c = '{start_volume: 6'd50, rem_level: 6'd5, vol_ceiling: 6'd40, volume_step: 6'd63,
          increase_period_ms: 20'd0, wake_stop_ms: 20'd30000, suppress_ms: 20'd0,
          idle_volume: 6'd0};
    apply_config(c);
    send_request(CMD_TRIGGER, 32'd10, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_POLL, 32'd20, STAGE_NREM, 1'b0);
    send_request(CMD_POLL, 32'd30, STAGE_REM, 1'b0);
    send_request(CMD_POLL, 32'd30, STAGE_UNKNOWN, 1'b0);
    send_request(CMD_STOP, 32'd40, STAGE_UNKNOWN, 1'b0);
  endtask

  task automatic test_random_sessions();
    sava_cfg_t         c;
    logic [TIME_W-1:0] t;
    logic [1:0]        stg;
    int                goal;
    int                polls;
    for (int phase = 0; phase < 8; phase++) begin
      c.start_volume = VOL_W'($urandom_range(0, 63));
      c.rem_level = VOL_W'($urandom_range(0, 63));
      c.vol_ceiling = VOL_W'($urandom_range(0, 63));
      c.volume_step = VOL_W'($urandom_range(0, 63));
      c.increase_period_ms = pick_ms();
      c.wake_stop_ms = pick_ms();
      c.suppress_ms = pick_ms();
      c.idle_volume = VOL_W'($urandom_range(0, 63));
      tx_gaps_on = (phase % 3) != 2;
      rx_stalls_on = (phase % 4) != 3;
      apply_config(c);
      t = $urandom;
      stg = STAGE_UNKNOWN;
      goal = live_items + 72;
      while (live_items < goal) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)));
        end else begin
          send_request(CMD_TRIGGER, t, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          polls = $urandom_range(1, 14);
          for (int k = 0; k < polls && alarm_on; k++) begin
            if ($urandom_range(0, 7) == 0)
              t += $urandom_range(0, 2 * int'(c.increase_period_ms) + 200);
            else
              t += $urandom_range(0, 1500);
            if ($urandom_range(0, 9) < 4) stg = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 14) == 0)
              send_request(CMD_STOP, t, stg, 1'($urandom_range(0, 1)));
            else
              send_request(CMD_POLL, t, stg, $urandom_range(0, 11) == 0);
          end
          if ($urandom_range(0, 1) == 1)
            t += $urandom_range(0, 2 * int'(c.suppress_ms) + 10);
          else
            t += $urandom_range(0, 500);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_START_VOLUME;
    cfg_wdata = '0;
    mismatches = 0;
    cycle_count = 0;
    live_items = 0;
    rx_wait = 0;
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
    alarm_cfg = '{start_volume: RST_START_VOLUME, rem_level: RST_REM_LEVEL,
                  vol_ceiling: RST_VOL_CEILING, volume_step: RST_VOLUME_STEP,
                  increase_period_ms: RST_INC_PERIOD_MS, wake_stop_ms: RST_WAKE_STOP_MS,
                  suppress_ms: RST_SUPPRESS_MS, idle_volume: RST_IDLE_VOLUME};
    alarm_on = 1'b0;
    cur_volume = RST_IDLE_VOLUME;
    prior_stage = STAGE_UNKNOWN;
    last_step_ms = '0;
    wake_since_ms = '0;
    quiet_until_ms = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_default_ramp();
    test_wake_zero_and_wrap();
    test_config_extremes();
    test_random_sessions();
    in_valid <= 1'b0;
    while (alarm_rsp_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sava_pkg.sv
design/sava_cfg_regs.sv
design/sava_core.sv
design/sleep_aware_alarm_volume_ramp.sv
tb/sv/testbench.sv
